@@ src/sts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, widths and command codes of the sorted table search core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int DEPTH   = 64;                 // table entries
  localparam int AW      = $clog2(DEPTH);      // table index width
  localparam int BW      = AW + 2;             // signed search bound width (-1 .. DEPTH)
  localparam int LEVELS  = $clog2(DEPTH + 1);  // worst-case probe count
  localparam int CNT_W   = 7;                  // entry_count register width
  localparam int POS_W   = 6;                  // position field width
  localparam int VAL_W   = 32;                 // entry / key width

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // one item moving down the cell chain
  typedef struct packed {
    logic                    valid;
    logic                    cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic signed [BW-1:0]    lo;
    logic signed [BW-1:0]    hi;
    logic                    found;
    logic [AW-1:0]           where;
  } item_t;

endpackage
`default_nettype wire

@@ src/sorted_table_search_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_search_core
// Table of signed 32-bit entries with load and binary search commands.
// ----------------------------------------------------------------------------
// Items flow through a chain of seven search cells, one per binary search
// level, and one item can be accepted every cycle while the chain does not
// stall. A search result passes from the entry register, which loads at the
// transfer edge, through two registers in each of the seven cells and then
// the output register; a load gives no result. Each cell keeps its own
// copy of the 64-entry table in a RAM and probes it once, so the chain
// length is log2(64)+1 cells. Loads travel the same chain and write
// every copy in turn, so a search always sees every load transferred before
// it. The chain stalls only when a search result reaches the end while the
// previous result is still held; otherwise items keep moving and new ones are
// taken. Entries never loaded read as undefined. entry_count is saturated to
// the table depth; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sorted_table_search_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel (entry_count)
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [sts_pkg::CNT_W-1:0]       cfg_data,
  // input item channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic                            command,
  input  wire logic [sts_pkg::POS_W-1:0]       position,
  input  wire logic signed [sts_pkg::VAL_W-1:0] value,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            found,
  output      logic [sts_pkg::POS_W-1:0]       match_position
);
  import sts_pkg::*;

  logic [CNT_W-1:0] entry_count;
  logic [BW-1:0]    count_sat;
  logic             advance;
  item_t            link [LEVELS+1];
  item_t            last;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // counts above the table depth search the whole table
  always_comb begin
    if (32'(entry_count) > 32'(DEPTH)) begin
      count_sat = BW'(DEPTH);
    end else begin
      count_sat = BW'(entry_count);
    end
  end

  assign last = link[LEVELS];

  // chain holds only when a search result is at the end and cannot leave
  assign advance  = !(out_valid && out_stall && last.valid && (last.cmd == CMD_SEARCH));
  assign in_stall = !advance;

  // entry register: start bounds for a search
  always_ff @(posedge clk) begin
    if (rst) begin
      link[0].valid <= 1'b0;
    end else if (advance) begin
      link[0].valid    <= in_valid;
      link[0].cmd      <= command;
      link[0].position <= position;
      link[0].value    <= value;
      link[0].lo       <= '0;
      link[0].hi       <= $signed(count_sat) - BW'(1);
      link[0].found    <= 1'b0;
      link[0].where    <= '0;
    end
  end

  // one cell per search level
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    sts_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .item_in (link[k]),
      .item_out(link[k+1])
    );
  end

  // output register, holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last.valid && (last.cmd == CMD_SEARCH)) begin
      out_valid      <= 1'b1;
      found          <= last.found;
      match_position <= last.found ? POS_W'(last.where) : '0;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/sts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/sts_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_cell
// One search level: a private table copy, one probe, one bound update.
// ----------------------------------------------------------------------------
module sts_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire sts_pkg::item_t item_in,
  output      sts_pkg::item_t item_out
);
  import sts_pkg::*;

  logic                 probe;
  logic                 load_wr;
  logic signed [BW-1:0] mid_full;
  logic [VAL_W-1:0]     rdata;

  item_t                b_item;
  logic                 b_probe;
  logic [AW-1:0]        b_mid;
  item_t                upd;
  logic signed [BW-1:0] mid_ext;

  always_comb begin
    probe    = item_in.valid && (item_in.cmd == CMD_SEARCH) && !item_in.found &&
               (item_in.lo <= item_in.hi);
    load_wr  = item_in.valid && (item_in.cmd == CMD_LOAD) &&
               (32'(item_in.position) < 32'(DEPTH));
    mid_full = item_in.lo + ((item_in.hi - item_in.lo) >>> 1);
  end

  sts_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (advance && load_wr),
    .waddr(AW'(item_in.position)),
    .wdata(item_in.value),
    .re   (advance && probe),
    .raddr(mid_full[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_item.valid <= 1'b0;
    end else if (advance) begin
      b_item  <= item_in;
      b_probe <= probe;
      b_mid   <= mid_full[AW-1:0];
    end
  end

  // compare probed entry against the key and narrow the bounds
  always_comb begin
    upd     = b_item;
    mid_ext = $signed({{(BW-AW){1'b0}}, b_mid});
    if (b_probe) begin
      if ($signed(rdata) == b_item.value) begin
        upd.found = 1'b1;
        upd.where = b_mid;
      end else if ($signed(rdata) < b_item.value) begin
        upd.lo = mid_ext + BW'(1);
      end else begin
        upd.hi = mid_ext - BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (advance) begin
      item_out <= upd;
    end
  end

endmodule
`default_nettype wire
